>>> design/maze_wall_region_merger_defines.svh
// Assertion macros used by the checker file of this block.
`ifndef MAZE_WALL_REGION_MERGER_DEFINES_SVH
`define MAZE_WALL_REGION_MERGER_DEFINES_SVH

// Same-cycle implication, muted while reset is asserted.
`define MWRM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, muted while reset is asserted.
`define MWRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/mwrm_pkg.sv
package mwrm_pkg;

	localparam int CELLS_PER_SIDE_DEF = 5;
	localparam int COORD_W = 4;
	localparam int JOIN_W = 5;

	typedef enum logic [1:0] {
		ST_BROKEN   = 2'd0,
		ST_JOINED   = 2'd1,
		ST_NOT_WALL = 2'd2
	} status_t;

endpackage

>>> design/mwrm_ifs.sv
interface mwrm_in_if;
	logic                             valid;
	logic                             ready;
	logic [mwrm_pkg::COORD_W-1:0]     row;
	logic [mwrm_pkg::COORD_W-1:0]     column;

	modport source (output valid, output row, output column, input ready);
	modport sink (input valid, input row, input column, output ready);
endinterface

interface mwrm_out_if;
	logic                             valid;
	logic                             ready;
	mwrm_pkg::status_t                status;
	logic [mwrm_pkg::JOIN_W-1:0]      joined_count;
	logic                             all_joined;

	modport source (output valid, output status, output joined_count, output all_joined,
		input ready);
	modport sink (input valid, input status, input joined_count, input all_joined,
		output ready);
endinterface

>>> design/mwrm_ram.sv
module mwrm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/mwrm_decode.sv
module mwrm_decode #(
	parameter int CELLS_PER_SIDE = mwrm_pkg::CELLS_PER_SIDE_DEF
) (
	input  logic [mwrm_pkg::COORD_W-1:0]                      row,
	input  logic [mwrm_pkg::COORD_W-1:0]                      column,
	output logic                                              is_wall,
	output logic [$clog2(CELLS_PER_SIDE*CELLS_PER_SIDE)-1:0]  idx_a,
	output logic [$clog2(CELLS_PER_SIDE*CELLS_PER_SIDE)-1:0]  idx_b
);

	localparam int AW = $clog2(CELLS_PER_SIDE * CELLS_PER_SIDE);
	localparam int GRID_SIDE = 2 * CELLS_PER_SIDE + 1;
	localparam int HW = mwrm_pkg::COORD_W - 1;

	logic          horiz;
	logic          vert;
	logic          in_grid;
	logic [HW-1:0] half_r;
	logic [HW-1:0] half_c;
	logic [HW-1:0] ra;
	logic [HW-1:0] ca;

	// A wall between two cells lies on an interior position of mixed parity.
	always_comb begin
		horiz   = !row[0] && column[0];
		vert    = row[0] && !column[0];
		in_grid = (row != '0) && (column != '0)
			&& (32'(row) < 32'(GRID_SIDE - 1)) && (32'(column) < 32'(GRID_SIDE - 1));
		is_wall = in_grid && (horiz || vert);
		half_r  = row[mwrm_pkg::COORD_W-1:1];
		half_c  = column[mwrm_pkg::COORD_W-1:1];
		// the first cell is above or to the left of the wall
		ra      = horiz ? half_r - HW'(1) : half_r;
		ca      = vert ? half_c - HW'(1) : half_c;
		idx_a   = AW'(32'(ra) * 32'(CELLS_PER_SIDE) + 32'(ca));
		idx_b   = AW'(32'(half_r) * 32'(CELLS_PER_SIDE) + 32'(half_c));
	end

endmodule

>>> design/maze_wall_region_merger.sv
// Region label merger for a square maze of CELLS_PER_SIDE x CELLS_PER_SIDE cells.
// Channel wall (sink): one beat names a grid position (row, column) to break.
// Channel result (source): one beat per wall beat with status (broken, already
// joined, not a breakable wall), the number of cells sharing the label of the
// top-left cell, and all_joined when every cell carries that label.
// Only cell labels are stored: wall and pillar labels never reach a result.
// A breakable wall first reads the labels of its two cells; any other position
// goes straight to the scan. wall.ready is low while an item is in work, so the
// next wall beat is taken only once the result of the last one is loaded.
// Each item makes one scan of the label RAM, one cell a cycle, through a
// shared compare unit that relabels and counts in the same pass.
// After reset the RAM is loaded with the row-major numbering, one cell a
// cycle; wall.ready stays low during that pass.
// A result beat waits in its output register while result.ready is low; the
// next wall beat is still taken, and its result waits until the register is free.
module maze_wall_region_merger #(
	parameter int CELLS_PER_SIDE = mwrm_pkg::CELLS_PER_SIDE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	mwrm_in_if.sink            wall,
	mwrm_out_if.source         result
);

	localparam int CELLS = CELLS_PER_SIDE * CELLS_PER_SIDE;
	localparam int AW = $clog2(CELLS);
	localparam int LW = $clog2(CELLS + 1);
	localparam int CW = $clog2(CELLS + 1);
	localparam int JOIN_W = mwrm_pkg::JOIN_W;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_RD_A,
		S_RD_B,
		S_SCAN,
		S_DRAIN,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     rd_idx_q;
	logic [AW-1:0]     idx_b_q;
	logic [LW-1:0]     label_a_q;
	logic [LW-1:0]     label_b_q;
	logic              merge_q;
	mwrm_pkg::status_t status_q;
	logic [LW-1:0]     ref_q;
	logic [CW-1:0]     count_q;
	logic              proc_vld_s1;
	logic [AW-1:0]     proc_idx_s1;
	logic              res_valid_q;
	mwrm_pkg::status_t res_status_q;
	logic [JOIN_W-1:0] res_count_q;
	logic              res_all_q;

	logic              dec_is_wall;
	logic [AW-1:0]     dec_idx_a;
	logic [AW-1:0]     dec_idx_b;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [LW-1:0]     ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [LW-1:0]     ram_rdata;

	logic              hit;
	logic [LW-1:0]     new_label;
	logic              same_ref;

	mwrm_decode #(
		.CELLS_PER_SIDE(CELLS_PER_SIDE)
	) u_decode (
		.row    (wall.row),
		.column (wall.column),
		.is_wall(dec_is_wall),
		.idx_a  (dec_idx_a),
		.idx_b  (dec_idx_b)
	);

	mwrm_ram #(
		.WIDTH(LW),
		.DEPTH(CELLS)
	) u_labels (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Shared compare unit: relabel the second region to the first and test
	// the result against the label of the top-left cell.
	always_comb begin
		hit       = merge_q && (ram_rdata == label_b_q);
		new_label = hit ? label_a_q : ram_rdata;
		same_ref  = (new_label == ref_q);
	end

	// Read port: the first cell on the accepting beat, then the second cell,
	// then the scan address.
	always_comb begin
		case (state_q)
			S_IDLE:  ram_raddr = dec_idx_a;
			S_RD_A:  ram_raddr = idx_b_q;
			default: ram_raddr = rd_idx_q;
		endcase
	end

	// Write port: the numbering pass after reset, else write back a relabelled cell.
	always_comb begin
		if (state_q == S_INIT) begin
			ram_we    = 1'b1;
			ram_waddr = rd_idx_q;
			ram_wdata = LW'(rd_idx_q) + LW'(1);
		end else begin
			ram_we    = proc_vld_s1 && hit;
			ram_waddr = proc_idx_s1;
			ram_wdata = new_label;
		end
	end

	assign wall.ready          = (state_q == S_IDLE);
	assign result.valid        = res_valid_q;
	assign result.status       = res_status_q;
	assign result.joined_count = res_count_q;
	assign result.all_joined   = res_all_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			rd_idx_q     <= '0;
			idx_b_q      <= '0;
			label_a_q    <= '0;
			label_b_q    <= '0;
			merge_q      <= 1'b0;
			status_q     <= mwrm_pkg::ST_NOT_WALL;
			ref_q        <= '0;
			count_q      <= '0;
			proc_vld_s1  <= 1'b0;
			proc_idx_s1  <= '0;
			res_valid_q  <= 1'b0;
			res_status_q <= mwrm_pkg::ST_NOT_WALL;
			res_count_q  <= '0;
			res_all_q    <= 1'b0;
		end else begin
			// drop the result once the receiver takes the beat, unless a new one loads
			if (res_valid_q && result.ready && (state_q != S_DONE)) begin
				res_valid_q <= 1'b0;
			end

			// count stage of the scan; the top-left cell comes first and sets the reference
			if (proc_vld_s1) begin
				if (proc_idx_s1 == '0) begin
					ref_q   <= new_label;
					count_q <= CW'(1);
				end else if (same_ref) begin
					count_q <= count_q + CW'(1);
				end
			end

			case (state_q)
				S_INIT: begin
					if (rd_idx_q == AW'(CELLS - 1)) begin
						rd_idx_q <= '0;
						state_q  <= S_IDLE;
					end else begin
						rd_idx_q <= rd_idx_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (wall.valid) begin
						rd_idx_q <= '0;
						if (dec_is_wall) begin
							idx_b_q <= dec_idx_b;
							state_q <= S_RD_A;
						end else begin
							merge_q  <= 1'b0;
							status_q <= mwrm_pkg::ST_NOT_WALL;
							state_q  <= S_SCAN;
						end
					end
				end
				S_RD_A: begin
					label_a_q <= ram_rdata;
					state_q   <= S_RD_B;
				end
				S_RD_B: begin
					label_b_q <= ram_rdata;
					merge_q   <= (label_a_q != ram_rdata);
					status_q  <= (label_a_q != ram_rdata) ? mwrm_pkg::ST_BROKEN
						: mwrm_pkg::ST_JOINED;
					state_q   <= S_SCAN;
				end
				S_SCAN: begin
					proc_vld_s1 <= 1'b1;
					proc_idx_s1 <= rd_idx_q;
					if (rd_idx_q == AW'(CELLS - 1)) begin
						state_q <= S_DRAIN;
					end else begin
						rd_idx_q <= rd_idx_q + AW'(1);
					end
				end
				S_DRAIN: begin
					proc_vld_s1 <= 1'b0;
					state_q     <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (!res_valid_q || result.ready) begin
						res_valid_q  <= 1'b1;
						res_status_q <= status_q;
						res_count_q  <= JOIN_W'(count_q);
						res_all_q    <= (count_q == CW'(CELLS));
						rd_idx_q     <= '0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_INIT;
				end
			endcase
		end
	end

endmodule

>>> design/mwrm_checker.sv
`include "maze_wall_region_merger_defines.svh"

module mwrm_checker #(
	parameter int CELLS_PER_SIDE = mwrm_pkg::CELLS_PER_SIDE_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        wall_valid,
	input logic                        wall_ready,
	input logic                        res_valid,
	input logic                        res_ready,
	input mwrm_pkg::status_t           res_status,
	input logic [mwrm_pkg::JOIN_W-1:0] res_count,
	input logic                        res_all
);

	localparam int JOIN_W = mwrm_pkg::JOIN_W;
	localparam int CELLS = CELLS_PER_SIDE * CELLS_PER_SIDE;

	`MWRM_ASSERT_NEXT(a_busy_after_beat, clk, arst_n, wall_valid && wall_ready, !wall_ready, "ready stayed high after a wall beat")
	`MWRM_ASSERT_NOW(a_all_joined_count, clk, arst_n, res_valid && res_all, res_count == JOIN_W'(CELLS), "all_joined with a short count")
	`MWRM_ASSERT_NEXT(a_valid_holds, clk, arst_n, res_valid && !res_ready, res_valid, "result dropped while stalled")
	`MWRM_ASSERT_NEXT(a_payload_holds, clk, arst_n, res_valid && !res_ready, $stable(res_status) && $stable(res_count) && $stable(res_all), "result changed while stalled")

endmodule

bind maze_wall_region_merger mwrm_checker #(
	.CELLS_PER_SIDE(CELLS_PER_SIDE)
) u_mwrm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.wall_valid(wall.valid),
	.wall_ready(wall.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_status(result.status),
	.res_count (result.joined_count),
	.res_all   (result.all_joined)
);

>>> tb/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Grid geometry: cells sit at odd row and odd column, everything else
	// is a wall or a pillar.
	localparam int SIDE_CELLS = mwrm_pkg::CELLS_PER_SIDE_DEF;
	localparam int GRID_SIDE = 2 * SIDE_CELLS + 1;
	localparam int CELL_COUNT = SIDE_CELLS * SIDE_CELLS;
	localparam int LABEL_W = $clog2(CELL_COUNT + 1);
	localparam int COORD_W = mwrm_pkg::COORD_W;
	localparam int JOIN_W = mwrm_pkg::JOIN_W;

	// Stimulus volume and run limits.
	localparam int RANDOM_WALLS = 1600;
	localparam int HOLD_AT_BEAT = 150;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = CELL_COUNT + 15;
	localparam int CYCLE_LIMIT = 600_000;

	// Directed walls: out-of-range corners, every border, a cell, a pillar,
	// horizontal and vertical breaks, a repeat, and a loop closure.
	localparam int DIRECTED_WALLS = 22;
	localparam logic [COORD_W-1:0] DIR_ROW [DIRECTED_WALLS] = '{
		4'd0, 4'd15, 4'd15, 4'd0, 4'd10, 4'd3, 4'd11, 4'd1, 4'd2, 4'd1, 4'd1,
		4'd2, 4'd2, 4'd3, 4'd8, 4'd9, 4'd5, 4'd6, 4'd4, 4'd0, 4'd9, 4'd12
	};
	localparam logic [COORD_W-1:0] DIR_COL [DIRECTED_WALLS] = '{
		4'd0, 4'd15, 4'd0, 4'd15, 4'd3, 4'd10, 4'd1, 4'd1, 4'd2, 4'd2, 4'd2,
		4'd1, 4'd3, 4'd2, 4'd9, 4'd8, 4'd10, 4'd5, 4'd5, 4'd5, 4'd0, 4'd7
	};

	typedef struct {
		mwrm_pkg::status_t      status;
		logic [JOIN_W-1:0]      joined_count;
		logic                   all_joined;
	} merge_outcome_t;

	// Region tracker: mirrors the label grid and queues the outcome of
	// every wall beat the block has taken.
	class maze_regions;
		logic [LABEL_W-1:0] labels [GRID_SIDE][GRID_SIDE];
		merge_outcome_t pending_outcomes[$];
		int failures;

		function new();
			int next_label;
			next_label = 1;
			failures = 0;
			for (int r = 0; r < GRID_SIDE; r++)
				for (int c = 0; c < GRID_SIDE; c++) begin
					if ((r % 2 == 1) && (c % 2 == 1)) begin
						labels[r][c] = LABEL_W'(next_label);
						next_label++;
					end else begin
						labels[r][c] = '0;
					end
				end
		endfunction

		function int pending();
			return pending_outcomes.size();
		endfunction

		function void note_wall(logic [COORD_W-1:0] row, logic [COORD_W-1:0] column);
			int r, c, ar, ac, br, bc, shared;
			bit is_wall;
			logic [LABEL_W-1:0] keep, drop, anchor;
			merge_outcome_t outcome;
			r = row;
			c = column;
			is_wall = 1'b0;
			ar = 0; ac = 0; br = 0; bc = 0;
			outcome.status = mwrm_pkg::ST_NOT_WALL;
			if (r > 0 && r < GRID_SIDE - 1 && c > 0 && c < GRID_SIDE - 1) begin
				if (r % 2 == 0 && c % 2 == 1) begin
					ar = r - 1; ac = c; br = r + 1; bc = c;
					is_wall = 1'b1;
				end else if (r % 2 == 1 && c % 2 == 0) begin
					ar = r; ac = c - 1; br = r; bc = c + 1;
					is_wall = 1'b1;
				end
			end
			if (is_wall) begin
				keep = labels[ar][ac];
				drop = labels[br][bc];
				if (keep != drop) begin
					labels[r][c] = keep;
					// drop was captured first, so later positions relabel too
					for (int k = 1; k < GRID_SIDE - 1; k++)
						for (int l = 1; l < GRID_SIDE - 1; l++)
							if (labels[k][l] == drop)
								labels[k][l] = keep;
					outcome.status = mwrm_pkg::ST_BROKEN;
				end else begin
					outcome.status = mwrm_pkg::ST_JOINED;
				end
			end
			anchor = labels[1][1];
			shared = 0;
			for (int k = 1; k < GRID_SIDE - 1; k += 2)
				for (int l = 1; l < GRID_SIDE - 1; l += 2)
					if (labels[k][l] == anchor)
						shared++;
			outcome.joined_count = JOIN_W'(shared);
			outcome.all_joined = (shared == CELL_COUNT);
			pending_outcomes.push_back(outcome);
		endfunction

		function void check_result(mwrm_pkg::status_t status,
				logic [JOIN_W-1:0] joined_count, logic all_joined);
			merge_outcome_t want;
			if (pending_outcomes.size() == 0) begin
				$display("%0t: result beat with nothing outstanding: status %0d count %0d all %0b",
					$time, status, joined_count, all_joined);
				failures++;
				return;
			end
			want = pending_outcomes.pop_front();
			if (status !== want.status) begin
				$display("%0t: status expected %0d, got %0d", $time, want.status, status);
				failures++;
			end
			if (joined_count !== want.joined_count) begin
				$display("%0t: joined_count expected %0d, got %0d", $time,
					want.joined_count, joined_count);
				failures++;
			end
			if (all_joined !== want.all_joined) begin
				$display("%0t: all_joined expected %0b, got %0b", $time,
					want.all_joined, all_joined);
				failures++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int cycles = 0;
	int send_streak = 0;
	int take_streak = 0;

	mwrm_in_if wall_ch();
	mwrm_out_if result_ch();

	maze_regions regions = new();

	maze_wall_region_merger #(
		.CELLS_PER_SIDE(SIDE_CELLS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.wall(wall_ch),
		.result(result_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort on a hung handshake; the limit is several times the slowest run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Draw a random idle gap, with the odd run of back-to-back beats
	// so that the block also sees stretches with no idling at all.
	function automatic int draw_idle(ref int streak);
		if (streak > 0) begin
			streak--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			streak = $urandom_range(8, 30);
			return 0;
		end
		return $urandom_range(0, 12);
	endfunction

	// Offer one wall beat after a random gap and hold it until it is taken.
	// Keep valid high across back-to-back beats rather than dropping it.
	task automatic send_wall(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] column);
		int gap;
		gap = draw_idle(send_streak);
		if (gap > 0) begin
			wall_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		wall_ch.valid <= 1'b1;
		wall_ch.row <= row;
		wall_ch.column <= column;
		do @(posedge clk); while (!(wall_ch.valid && wall_ch.ready));
	endtask

	// Pick an interior wall between two cells, either orientation.
	task automatic random_inner_wall(output logic [COORD_W-1:0] row,
			output logic [COORD_W-1:0] column);
		if ($urandom_range(0, 1)) begin
			row = COORD_W'(2 * $urandom_range(1, SIDE_CELLS - 1));
			column = COORD_W'(2 * $urandom_range(0, SIDE_CELLS - 1) + 1);
		end else begin
			row = COORD_W'(2 * $urandom_range(0, SIDE_CELLS - 1) + 1);
			column = COORD_W'(2 * $urandom_range(1, SIDE_CELLS - 1));
		end
	endtask

	// Note every wall beat the block takes, sampled before this edge's updates.
	always @(posedge clk) begin
		if (arst_n && wall_ch.valid && wall_ch.ready)
			regions.note_wall(wall_ch.row, wall_ch.column);
	end

	// Check every result beat against the oldest outstanding outcome.
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			regions.check_result(result_ch.status, result_ch.joined_count,
				result_ch.all_joined);
	end

	// Result side: stall at random before each beat; once, hold off for a
	// long stretch so the output register fills and the wall side backs up.
	initial begin
		int stall;
		int taken;
		taken = 0;
		result_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = draw_idle(take_streak);
			if (taken == HOLD_AT_BEAT)
				stall = HOLD_CYCLES;
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
			taken++;
		end
	end

	// Wall side: reset, directed walls, then random ones, then drain.
	initial begin
		logic [COORD_W-1:0] row, column;
		arst_n <= 1'b0;
		wall_ch.valid <= 1'b0;
		wall_ch.row <= '0;
		wall_ch.column <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_WALLS; i++)
			send_wall(DIR_ROW[i], DIR_COL[i]);

		// Mostly inner walls so regions keep merging; the rest is raw noise
		// over the whole 4-bit range, borders and out-of-grid positions included.
		for (int i = 0; i < RANDOM_WALLS; i++) begin
			if ($urandom_range(0, 9) < 8) begin
				random_inner_wall(row, column);
			end else begin
				row = COORD_W'($urandom_range(0, 15));
				column = COORD_W'($urandom_range(0, 15));
			end
			send_wall(row, column);
		end
		wall_ch.valid <= 1'b0;

		// Wait out the outstanding results, then watch for stray beats.
		while (regions.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (regions.failures == 0 && regions.pending() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
